// File: rtl/crc32s8_pkg.sv
// Shared types, constants and CRC-32 fold functions for the slice-by-eight CRC engine.
package crc32s8_pkg;

    // Bytes that one request carries at most.
    localparam int DATA_BYTES_MAX = 8;
    localparam int BYTES_PER_ITEM_DEF = 8;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam int PADDR_W = 3;

    // Configuration register indexes, taken from paddr[2].
    typedef enum logic {
        REG_SEED   = 1'b0,
        REG_INVERT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] data_bytes;
        logic [3:0]  byte_count;
        logic        first_item;
        logic        last_item;
    } t_crc_in;

    typedef struct packed {
        logic [31:0] crc_value;
        logic        is_last;
    } t_crc_out;

    // Contents of the lane stage register handed to the fold stage.
    typedef struct packed {
        logic [31:0] contrib;
        logic [3:0]  byte_count;
        logic        first_item;
        logic        last_item;
    } t_stage;

    // One byte through the reflected CRC-32, least significant bit first.
    function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                  input logic [7:0]  data_byte);
        logic [31:0] c;
        c = crc ^ {24'h000000, data_byte};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // Contribution of one byte folded from a zero state and then carried
    // through a fixed number of trailing zero bytes.
    function automatic logic [31:0] crc_lane_contrib(input logic [7:0] data_byte,
                                                     input int         advance);
        logic [31:0] c;
        c = crc_fold_byte(32'h0000_0000, data_byte);
        for (int i = 0; i < DATA_BYTES_MAX - 1; i++) begin
            if (i < advance) begin
                c = crc_fold_byte(c, 8'h00);
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/crc32s8_lane.sv
// One CRC lane: the fixed XOR network that maps one aligned byte to its CRC contribution.
module crc32s8_lane #(
    parameter int ADVANCE = 0
) (
    input  logic [7:0]  i_byte,
    output logic [31:0] o_contrib
);
    import crc32s8_pkg::*;

    assign o_contrib = crc_lane_contrib(i_byte, ADVANCE);

endmodule

// File: rtl/crc32s8_fold.sv
// Fold stage: running CRC register, zero-byte advance of the start value and the result register.
module crc32s8_fold #(
    parameter int LANES = crc32s8_pkg::BYTES_PER_ITEM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  crc32s8_pkg::t_stage   i_stage,
    input  logic [31:0]           i_seed,
    input  logic                  i_invert,
    output crc32s8_pkg::t_crc_out o_result
);
    import crc32s8_pkg::*;

    localparam int SEL_W = $clog2(LANES + 1);

    logic [31:0] r_running;
    logic [31:0] n_running;
    t_crc_out    r_result;
    t_crc_out    n_result;
    logic [31:0] start_crc;
    logic [31:0] cand [LANES+1];

    // The start value is carried through as many zero bytes as the request
    // held; the lane stage already supplied the data part of the remainder.
    always_comb begin
        start_crc = i_stage.first_item ? i_seed : r_running;
        cand[0] = start_crc;
        for (int i = 1; i <= LANES; i++) begin
            cand[i] = crc_fold_byte(cand[i-1], 8'h00);
        end
        n_running = cand[i_stage.byte_count[SEL_W-1:0]] ^ i_stage.contrib;
        n_result.crc_value = i_invert ? (n_running ^ CRC_ONES) : n_running;
        n_result.is_last = i_stage.last_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= CRC_ONES;
        end else if (i_load) begin
            r_running <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// File: rtl/crc32_slice8_engine.sv
// Top level of the reflected CRC-32 engine: request handshake, lanes, merge and register port.
//
// This block computes the reflected IEEE 802.3 CRC-32 (polynomial 0xEDB88320) over a byte
// stream and accepts one request of up to BYTES_PER_ITEM bytes (at most eight) every clock
// cycle while o_in_stall is low; each request returns exactly one result, in order.
// Byte 0 in bits 7:0 of data_bytes is the first byte of the stream, and byte_count valid
// bytes are taken from the low end, a larger count being clipped to the lane count. A request
// with first_item set restarts the running CRC from the seed register; otherwise it continues
// from the value left by the previous request, and after reset that value is all ones. The
// result carries the CRC after the request, XORed with all ones when invert_output is set,
// and echoes last_item in is_last. The first stage aligns the valid bytes to the top lane so
// that every lane has a fixed position, lets the lanes compute their byte contributions side
// by side and merges them with an XOR tree. The second stage holds the only loop: it takes
// the seed or the running CRC, carries it across the request's byte count of zero bytes and
// adds the merged data term combinationally, so without stalls the rate is one request per cycle.
// The result sits in an output register; the input side keeps accepting while that register
// waits, and only stalls when both the lane stage and the output register are occupied and the
// consumer stalls. Registers are written over the APB port: seed at address 0 and
// invert_output at address 4, with paddr bits 1:0 ignored; both should only be written while
// the engine holds no request.
module crc32_slice8_engine #(
    parameter int BYTES_PER_ITEM = crc32s8_pkg::BYTES_PER_ITEM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input request channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  crc32s8_pkg::t_crc_in              i_in_data,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output crc32s8_pkg::t_crc_out             o_out_data,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crc32s8_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import crc32s8_pkg::*;

    // The data field carries eight bytes, so lanes beyond eight would never see data.
    localparam int LANES  = (BYTES_PER_ITEM < DATA_BYTES_MAX) ? BYTES_PER_ITEM
                                                               : DATA_BYTES_MAX;
    localparam int LANE_W = LANES * 8;

    // Configuration registers.
    logic [31:0] r_seed;
    logic [31:0] n_seed;
    logic        r_invert;
    logic        n_invert;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    // Handshake and pipeline control.
    logic        r_s1_valid;
    logic        n_s1_valid;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        in_fire;
    logic        out_fire;
    logic        out_free;
    logic        xfer;

    // Lane stage.
    logic [3:0]        sat_count;
    logic [3:0]        shift_bytes;
    logic [LANE_W-1:0] aligned;
    logic [31:0]       lane_contrib [LANES];
    logic [31:0]       merged;
    t_stage            r_stage;
    t_stage            n_stage;

    // ------------------------------------------------------------------
    // Register port. Writes complete in the access phase; pready is tied high.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        n_seed   = r_seed;
        n_invert = r_invert;
        if (cfg_wr) begin
            case (cfg_idx)
                REG_SEED:   n_seed   = pwdata;
                REG_INVERT: n_invert = pwdata[0];
                default: begin
                    n_seed   = r_seed;
                    n_invert = r_invert;
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SEED:   prdata = r_seed;
            REG_INVERT: prdata = {31'h0000_0000, r_invert};
            default:    prdata = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= CRC_ONES;
            r_invert <= 1'b1;
        end else begin
            r_seed   <= n_seed;
            r_invert <= n_invert;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The lane stage moves on whenever the output register is
    // empty or being drained, so a waiting result never blocks the input
    // unless the lane stage behind it is also full.
    // ------------------------------------------------------------------
    assign out_fire   = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign xfer       = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (xfer) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (xfer) begin
            n_out_valid = 1'b1;
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Lane stage. The valid bytes are shifted up so that the last one lands
    // in the top lane. Leading zero bytes leave a zero CRC state unchanged,
    // so each lane can apply a fixed advance: lane j is followed by
    // LANES-1-j bytes in every request.
    // ------------------------------------------------------------------
    assign sat_count   = (i_in_data.byte_count > 4'(LANES)) ? 4'(LANES)
                                                             : i_in_data.byte_count;
    assign shift_bytes = 4'(LANES) - sat_count;
    assign aligned     = i_in_data.data_bytes[LANE_W-1:0] << {shift_bytes, 3'b000};

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        crc32s8_lane #(
            .ADVANCE (LANES - 1 - j)
        ) u_lane (
            .i_byte    (aligned[8*j +: 8]),
            .o_contrib (lane_contrib[j])
        );
    end

    // Merge: the CRC is linear, so the lane contributions simply XOR together.
    always_comb begin
        merged = 32'h0000_0000;
        for (int j = 0; j < LANES; j++) begin
            merged = merged ^ lane_contrib[j];
        end
        n_stage.contrib    = merged;
        n_stage.byte_count = sat_count;
        n_stage.first_item = i_in_data.first_item;
        n_stage.last_item  = i_in_data.last_item;
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_stage <= n_stage;
        end
    end

    // ------------------------------------------------------------------
    // Fold stage: running CRC and the output register.
    // ------------------------------------------------------------------
    crc32s8_fold #(
        .LANES (LANES)
    ) u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (xfer),
        .i_stage  (r_stage),
        .i_seed   (r_seed),
        .i_invert (r_invert),
        .o_result (o_out_data)
    );

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input only stalls when both stages hold a request and the consumer stalls.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled while the pipeline had room");

    // An accepted request always occupies the lane stage on the next cycle.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted request lost before the lane stage");

    // A drained output with an empty lane stage leaves no result behind.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !r_s1_valid) |=> !o_out_valid)
        else $error("result shown without a request behind it");

endmodule
